### hdl/flash_command_sequencer_core_defines.svh
// Assertion macros for the flash command sequencer.
// Used by flash_command_sequencer_core; depends on clk and rst_n being in scope.
`ifndef FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// implication check, sampled on clk, off during reset
`define FCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never be seen
`define FCS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define FCS_ASSERT(lbl, prop, msg)
`define FCS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### hdl/fcs_pkg.sv
// Shared types and constants for the flash command sequencer.
// No dependencies.
package fcs_pkg;

    localparam int ADDR_BITS_DEF = 20;

    // command modes
    typedef enum logic [2:0] {
        CMD_NONE        = 3'd0,
        CMD_ID          = 3'd1,
        CMD_ERASE_SETUP = 3'd2,
        CMD_ERASE_BUSY  = 3'd3,
        CMD_PROGRAM     = 3'd4,
        CMD_UNKNOWN     = 3'd5
    } cmd_mode_t;

    // unlock progress
    localparam logic [1:0] STEP_IDLE     = 2'd0;
    localparam logic [1:0] STEP_FIRST    = 2'd1;
    localparam logic [1:0] STEP_UNLOCKED = 2'd2;

    // magic offsets and values
    localparam logic [31:0] OFF_UNLOCK_A = 32'h0000_AAAA;
    localparam logic [31:0] OFF_UNLOCK_B = 32'h0000_5554;
    localparam logic [31:0] VAL_UNLOCK_A = 32'h0000_00AA;
    localparam logic [31:0] VAL_UNLOCK_B = 32'h0000_0055;

    localparam logic [31:0] OP_ID_ENTRY    = 32'h0000_0090;
    localparam logic [31:0] OP_ID_EXIT     = 32'h0000_00F0;
    localparam logic [31:0] OP_ERASE_SETUP = 32'h0000_0080;
    localparam logic [31:0] OP_CHIP_ERASE  = 32'h0000_0010;
    localparam logic [31:0] OP_PROGRAM     = 32'h0000_00A0;

    localparam logic [31:0] ID_MANUF     = 32'h0000_00BF;
    localparam logic [31:0] ID_DEVICE    = 32'h0000_2781;
    localparam logic [31:0] STATUS_MASK  = 32'h0000_0040;

    localparam logic [31:0] OFF_ID_MANUF  = 32'd0;
    localparam logic [31:0] OFF_ID_DEVICE = 32'd2;

    // access sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;

    // sequencer states
    typedef enum logic {
        SEQ_IDLE = 1'b0,
        SEQ_READ = 1'b1
    } seq_state_t;

    // command controller status toward the datapath
    typedef struct packed {
        cmd_mode_t mode;
        logic      program_write;
    } cmd_stat_t;

endpackage

### hdl/fcs_lane_ram.sv
// One byte lane of the flash array: single-port synchronous RAM.
// No dependencies.
module fcs_lane_ram #(
    parameter int ROW_BITS = 18
) (
    input  logic                clk,
    input  logic                en,
    input  logic                we,
    input  logic [ROW_BITS-1:0] row,
    input  logic [7:0]          wdata,
    output logic [7:0]          rdata
);

    logic [7:0] mem [0:(1 << ROW_BITS)-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[row] <= wdata;
            else
                rdata <= mem[row];
        end
    end

endmodule

### hdl/fcs_array.sv
// Flash byte array as four interleaved lanes; unaligned wrapping access.
// Depends on fcs_lane_ram.
module fcs_array #(
    parameter int ADDR_BITS = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] off,
    input  logic [15:0]          wr_half,
    output logic [31:0]          rd_word
);

    localparam int ROW_BITS = ADDR_BITS - 2;

    logic [7:0] lane_q [0:3];
    logic [1:0] rot_reg;
    logic [1:0] rot_next;

    // byte n of the access lives in lane (off+n) mod 4
    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        localparam logic [1:0] LANE = 2'(l);
        logic [ROW_BITS-1:0] row;
        logic                we;
        logic [7:0]          wd;

        assign row = off[ADDR_BITS-1:2] + ROW_BITS'((LANE < off[1:0]) ? 1 : 0);
        assign we  = wr_en && ((LANE == off[1:0]) || (LANE == off[1:0] + 2'd1));
        assign wd  = (LANE == off[1:0]) ? wr_half[7:0] : wr_half[15:8];

        fcs_lane_ram #(.ROW_BITS(ROW_BITS)) u_ram (
            .clk   (clk),
            .en    (rd_en || we),
            .we    (we),
            .row   (row),
            .wdata (wd),
            .rdata (lane_q[l])
        );
    end

    assign rot_next = rd_en ? off[1:0] : rot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rot_reg <= 2'd0;
        else
            rot_reg <= rot_next;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            rd_word[8*i +: 8] = lane_q[rot_reg + 2'(i)];
    end

endmodule

### hdl/fcs_cmd_ctrl.sv
// Unlock step and command mode tracking for the flash command set.
// Depends on fcs_pkg.
module fcs_cmd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_strobe,
    input  logic              rd_done,
    input  logic [31:0]       offset,
    input  logic [31:0]       wdata,
    output fcs_pkg::cmd_stat_t stat
);

    import fcs_pkg::*;

    logic [1:0] step_reg;
    logic [1:0] step_next;
    cmd_mode_t  mode_reg;
    cmd_mode_t  mode_next;
    logic       prog_wr;
    logic       hit_a;
    logic       hit_b;

    assign hit_a = (offset == OFF_UNLOCK_A);
    assign hit_b = (offset == OFF_UNLOCK_B);

    always_comb
    begin
        step_next = step_reg;
        mode_next = mode_reg;
        prog_wr   = 1'b0;
        if (wr_strobe)
        begin
            case (step_reg)
                STEP_IDLE:
                begin
                    if (hit_a && (wdata == VAL_UNLOCK_A))
                        step_next = STEP_FIRST;
                end
                STEP_FIRST:
                begin
                    step_next = (hit_b && (wdata == VAL_UNLOCK_B)) ? STEP_UNLOCKED : STEP_IDLE;
                end
                default:
                begin
                    if (hit_a)
                    begin
                        step_next = STEP_IDLE;
                        if (wdata == OP_ID_ENTRY)
                            mode_next = CMD_ID;
                        else if (wdata == OP_ID_EXIT)
                            mode_next = CMD_NONE;
                        else if (wdata == OP_ERASE_SETUP)
                            mode_next = CMD_ERASE_SETUP;
                        else if (wdata == OP_CHIP_ERASE)
                            mode_next = CMD_ERASE_BUSY;
                        else if (wdata == OP_PROGRAM)
                        begin
                            mode_next = CMD_PROGRAM;
                            step_next = STEP_UNLOCKED;
                        end
                        else
                            mode_next = CMD_UNKNOWN;
                    end
                    else if (mode_reg == CMD_ERASE_SETUP)
                    begin
                        mode_next = CMD_ERASE_BUSY;
                        step_next = STEP_IDLE;
                    end
                    else if (mode_reg == CMD_PROGRAM)
                        prog_wr = 1'b1;
                    else
                        step_next = STEP_IDLE;
                end
            endcase
        end
        else if (rd_done && (mode_reg inside {CMD_ERASE_BUSY, CMD_PROGRAM}))
        begin
            // status read ends the operation
            mode_next = CMD_NONE;
            step_next = STEP_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            mode_reg <= CMD_NONE;
        end
        else
        begin
            step_reg <= step_next;
            mode_reg <= mode_next;
        end
    end

    assign stat.mode          = mode_reg;
    assign stat.program_write = prog_wr;

endmodule

### hdl/flash_command_sequencer_core.sv
// Top level of the flash command sequencer: bus access handshake, window
// offset, read response path. Depends on fcs_pkg, fcs_array, fcs_cmd_ctrl
// and flash_command_sequencer_core_defines.svh.
//
//   channel   ports                                       transfer when
//   access    start, busy, mode, bus_address,             start && !busy
//             access_size, write_data
//   result    read_valid, read_data                       read_valid (one cycle)
//   config    cfg_valid, cfg_ready, cfg_data              cfg_valid && cfg_ready
//
// A write is not held by busy: command state and any program write to the lane
// RAMs update at the accepting edge. A read holds busy in SEQ_READ while the lane
// RAMs deliver their registered data; read_valid/read_data are registered from
// that state and carry the result in the cycle in which the next access can be
// accepted. Reset is asynchronous, active low, and clears control state only;
// array contents stay as loaded. The receiver cannot stall results.
`include "flash_command_sequencer_core_defines.svh"

module flash_command_sequencer_core #(
    parameter int ADDR_BITS = fcs_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // access channel
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [31:0] bus_address,
    input  logic [1:0]  access_size,
    input  logic [31:0] write_data,
    // result channel
    output logic        read_valid,
    output logic [31:0] read_data,
    // configuration channel (window_base)
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    import fcs_pkg::*;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [31:0] window_base_reg;
    logic [31:0] window_base_next;
    logic [31:0] offset;
    logic        accept;
    logic        rd_start;
    logic        wr_start;
    logic        rd_done;

    // latched per-read attributes
    logic [1:0]  size_reg;
    logic [1:0]  size_next;
    logic        at_manuf_reg;
    logic        at_manuf_next;
    logic        at_device_reg;
    logic        at_device_next;

    logic [31:0] rd_word;
    logic [31:0] raw_data;
    logic [31:0] result;
    logic [31:0] read_data_reg;
    logic [31:0] read_data_next;
    logic        read_valid_reg;
    logic        read_valid_next;

    cmd_stat_t   cmd_stat;

    assign accept   = start && !busy;
    assign rd_start = accept && !mode;
    assign wr_start = accept && mode;
    assign offset   = bus_address - window_base_reg;

    // ---------------- control sequence ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (rd_start)
                    state_next = SEQ_READ;
            end
            SEQ_READ:
                state_next = SEQ_IDLE;
            default:
                state_next = SEQ_IDLE;
        endcase
    end

    always_comb
    begin
        busy    = 1'b0;
        rd_done = 1'b0;
        case (state_reg)
            SEQ_IDLE:
                busy = 1'b0;
            SEQ_READ:
            begin
                busy    = 1'b1;
                rd_done = 1'b1;
            end
            default:
                busy = 1'b1;
        endcase
    end

    // config only lands while no read is in progress (not busy)
    assign cfg_ready        = !busy;
    assign window_base_next = (cfg_valid && cfg_ready) ? cfg_data : window_base_reg;

    assign size_next      = rd_start ? access_size : size_reg;
    assign at_manuf_next  = rd_start ? (offset == OFF_ID_MANUF) : at_manuf_reg;
    assign at_device_next = rd_start ? (offset == OFF_ID_DEVICE) : at_device_reg;

    // ---------------- storage and command state ----------------
    fcs_array #(.ADDR_BITS(ADDR_BITS)) u_array (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_start),
        .wr_en   (cmd_stat.program_write),
        .off     (offset[ADDR_BITS-1:0]),
        .wr_half (write_data[15:0]),
        .rd_word (rd_word)
    );

    fcs_cmd_ctrl u_cmd (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_strobe (wr_start),
        .rd_done   (rd_done),
        .offset    (offset),
        .wdata     (write_data),
        .stat      (cmd_stat)
    );

    // ---------------- read response ----------------
    always_comb
    begin
        case (size_reg)
            SIZE_BYTE: raw_data = {24'd0, rd_word[7:0]};
            SIZE_HALF: raw_data = {16'd0, rd_word[15:0]};
            default:   raw_data = rd_word;
        endcase
    end

    // mode is unchanged between accept and SEQ_READ
    always_comb
    begin
        case (cmd_stat.mode)
            CMD_NONE:
                result = raw_data;
            CMD_ID:
            begin
                if (at_manuf_reg)
                    result = ID_MANUF;
                else if (at_device_reg)
                    result = ID_DEVICE;
                else
                    result = raw_data;
            end
            CMD_ERASE_BUSY, CMD_PROGRAM:
                result = raw_data & STATUS_MASK;
            default:
                result = 32'd0;
        endcase
    end

    assign read_data_next  = rd_done ? result : read_data_reg;
    assign read_valid_next = rd_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SEQ_IDLE;
            window_base_reg <= 32'd0;
            read_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_base_reg <= window_base_next;
            read_valid_reg  <= read_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg      <= size_next;
        at_manuf_reg  <= at_manuf_next;
        at_device_reg <= at_device_next;
        read_data_reg <= read_data_next;
    end

    assign read_valid = read_valid_reg;
    assign read_data  = read_data_reg;

    // ---------------- checks ----------------
    `FCS_ASSERT(a_result_after_read, (rd_start |-> ##2 read_valid), "read gave no result")
    `FCS_ASSERT(a_write_no_result, (wr_start |=> !read_valid), "write produced a result")
    `FCS_ASSERT(a_result_source, (read_valid |-> $past(state_reg == SEQ_READ)), "stray result")
    `FCS_ASSERT_NEVER(a_prog_wr, cmd_stat.program_write && cmd_stat.mode != CMD_PROGRAM, "bad write")

endmodule
